// ----- rtl/b64d_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character-to-sextet function of the base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam int         EXP_WIDTH    = 12;
  localparam logic [EXP_WIDTH-1:0] EXP_RESET = 12'd32;
  localparam int         QDEPTH       = 4;
  localparam int         QPTR_WIDTH   = $clog2(QDEPTH);
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [7:0] DIGIT_OFFSET = 8'd52;
  localparam logic [7:0] LOWER_OFFSET = 8'd26;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_TOO_SHORT  = 2'd3
  } status_t;

  // One queue entry: a decoded group and, at the end of a string, its status.
  typedef struct packed {
    logic [23:0] val;
    logic [1:0]  nbytes;
    logic        has_status;
    status_t     code;
  } group_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h61 + LOWER_OFFSET;
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30 + DIGIT_OFFSET;
    end else if (c == 8'h2B) begin
      t = {2'b00, SEXTET_PLUS};
    end else if (c == 8'h2F) begin
      t = {2'b00, SEXTET_SLASH};
    end
    return t[5:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/base64_decoder_with_length_check_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// base64_decoder_with_length_check_unit
// Streaming base64 decoder that checks the decoded length against a
// configured byte count and closes every string with a status item.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  in       | in        | in_valid / in_stall   | in_char, final_char
//  out      | out       | out_valid / out_stall | out_byte, is_status,
//           |           |                       | status_code, run_end
//  cfg      | in        | cfg_valid / cfg_ready | cfg_data (expected_bytes)
//
// A character is taken in every cycle with in_stall low; a result leaves in
// every cycle with one queued and out_stall low, through the output register.
// Four results at most follow one character; a four-entry group queue
// absorbs them, and in_stall is high only while that queue is full.
// Synchronous reset clears all stream state and sets expected_bytes to 32.
// ---------------------------------------------------------------------------
module base64_decoder_with_length_check_unit #(
  parameter int COUNT_WIDTH = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_char,
  input  wire logic                           final_char,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte,
  output logic                                is_status,
  output logic [1:0]                          status_code,
  output logic                                run_end,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [b64d_pkg::EXP_WIDTH-1:0] cfg_data
);

  logic             accept;
  logic             q_push;
  b64d_pkg::group_t q_push_data;
  logic             q_pop;
  b64d_pkg::group_t q_head;
  logic             q_full;
  logic             q_empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_char   (in_char),
    .final_char(final_char),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .push_data (q_push_data)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_status  (is_status),
    .status_code(status_code),
    .run_end    (run_end)
  );

  // The queue is never written while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("group queue written while full");

  // A status item always closes the results of its character.
  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> run_end && (out_byte == 8'd0))
    else $error("status item without run_end or with a non-zero byte");

  // Data items carry no status code.
  a_data_code_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> (status_code == b64d_pkg::ST_OK))
    else $error("data item with a status code");

  // Nothing is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("group queue read while empty");

endmodule
`default_nettype wire

// ----- rtl/b64d_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_front
// Accepts characters, packs sextets into groups, keeps the byte count and
// judges the length at the final character.
// ---------------------------------------------------------------------------
module b64d_front #(
  parameter int COUNT_WIDTH = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [7:0]                    in_char,
  input  wire logic                          final_char,
  input  wire logic                          cfg_valid,
  input  wire logic [b64d_pkg::EXP_WIDTH-1:0] cfg_data,
  output logic                               push,
  output b64d_pkg::group_t                   push_data
);

  localparam int CMP_W = (COUNT_WIDTH > b64d_pkg::EXP_WIDTH) ? COUNT_WIDTH
                                                             : b64d_pkg::EXP_WIDTH;

  logic [b64d_pkg::EXP_WIDTH-1:0] expected_bytes;
  logic [17:0]                    acc;
  logic [1:0]                     pos;
  logic                           prev_pad;
  logic [COUNT_WIDTH-1:0]         count;

  logic                   is_pad;
  logic [5:0]             sextet;
  logic [1:0]             nbytes;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       exp_ext;
  b64d_pkg::status_t      code;

  always_comb begin
    is_pad = (in_char == b64d_pkg::PAD_CHAR);
    sextet = is_pad ? 6'd0 : b64d_pkg::sextet_of(in_char);
    nbytes = 2'd3;
    if (final_char) begin
      nbytes = nbytes - {1'b0, is_pad} - {1'b0, prev_pad};
    end
    sum = {1'b0, count} + (COUNT_WIDTH + 1)'(nbytes);
    // The count sticks at its top value rather than wrapping.
    count_next = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    cnt_ext = CMP_W'(count_next);
    exp_ext = CMP_W'(expected_bytes);
    if (pos != 2'd3) begin
      code = b64d_pkg::ST_BAD_LENGTH;
    end else if (cnt_ext > exp_ext) begin
      code = b64d_pkg::ST_TOO_LONG;
    end else if (cnt_ext < exp_ext) begin
      code = b64d_pkg::ST_TOO_SHORT;
    end else begin
      code = b64d_pkg::ST_OK;
    end
  end

  always_comb begin
    push                 = accept && ((pos == 2'd3) || final_char);
    push_data.val        = {acc, sextet};
    push_data.nbytes     = (pos == 2'd3) ? nbytes : 2'd0;
    push_data.has_status = final_char;
    push_data.code       = final_char ? code : b64d_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= b64d_pkg::EXP_RESET;
    end else if (cfg_valid) begin
      expected_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      pos      <= '0;
      prev_pad <= 1'b0;
      count    <= '0;
    end else if (accept) begin
      if (final_char) begin
        // The string is finished: everything returns to its starting value.
        acc      <= '0;
        pos      <= '0;
        prev_pad <= 1'b0;
        count    <= '0;
      end else begin
        prev_pad <= is_pad;
        if (pos == 2'd3) begin
          acc   <= '0;
          pos   <= '0;
          count <= count_next;
        end else begin
          acc <= {acc[11:0], sextet};
          pos <= pos + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b64d_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of decoded groups between front and back.
// ---------------------------------------------------------------------------
module b64d_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b64d_pkg::group_t  push_data,
  input  wire logic              pop,
  output b64d_pkg::group_t       head,
  output logic                   full,
  output logic                   empty
);

  b64d_pkg::group_t                  entries [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_WIDTH-1:0]   wr_ptr;
  logic [b64d_pkg::QPTR_WIDTH-1:0]   rd_ptr;
  logic [b64d_pkg::QPTR_WIDTH:0]     fill;

  assign full  = (fill == (b64d_pkg::QPTR_WIDTH + 1)'(b64d_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b64d_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_back
// Walks the group at the head of the queue and issues one result per cycle
// into the output register unless the queue is empty or out_stall holds it.
// ---------------------------------------------------------------------------
module b64d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64d_pkg::group_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   is_status,
  output logic [1:0]             status_code,
  output logic                   run_end
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       last;
  logic       load;
  logic       st_item;
  logic [7:0] sel_byte;

  always_comb begin
    total   = {1'b0, head.nbytes} + {2'b00, head.has_status};
    last    = (({1'b0, idx} + 3'd1) == total);
    load    = !empty && (!out_valid || !out_stall);
    pop     = load && last;
    st_item = (idx == head.nbytes);
    case (idx)
      2'd0:    sel_byte = head.val[23:16];
      2'd1:    sel_byte = head.val[15:8];
      2'd2:    sel_byte = head.val[7:0];
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= st_item ? 8'd0 : sel_byte;
      is_status   <= st_item;
      status_code <= st_item ? head.code : b64d_pkg::ST_OK;
      run_end     <= last;
    end
  end

endmodule
`default_nettype wire

// ----- sim/b64d_stream_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// b64d_stream_checker
// Watches the character, result and register channels of the base64
// decoder, keeps its own model of the decoding state and compares every
// result transaction against the oldest predicted one.
// ---------------------------------------------------------------------------
module b64d_stream_checker #(
  parameter int COUNT_WIDTH = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [7:0]                     in_char,
  input  wire logic                           final_char,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [7:0]                     out_byte,
  input  wire logic                           is_status,
  input  wire logic [1:0]                     status_code,
  input  wire logic                           run_end,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [b64d_pkg::EXP_WIDTH-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  results_checked
);

  typedef struct packed {
    logic [7:0]        data;
    logic              is_stat;
    b64d_pkg::status_t code;
    logic              last;
  } decoded_t;

  decoded_t due_q[$];

  logic [17:0]                    acc;
  logic [1:0]                     pos;
  logic                           prev_pad;
  logic [COUNT_WIDTH-1:0]         byte_total;
  logic [b64d_pkg::EXP_WIDTH-1:0] want_bytes;
  int                             errors = 0;
  int                             seen = 0;

  function automatic logic [5:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  task automatic report(input string what, input decoded_t want, input decoded_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected byte %02h status %0b code %0d end %0b,",
               $time, what, want.data, want.is_stat, want.code, want.last);
      $display("    got byte %02h status %0b code %0d end %0b",
               got.data, got.is_stat, got.code, got.last);
    end
  endtask

  // Works out the results that one accepted character causes.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    decoded_t               burst[4];
    logic                   pad;
    logic [5:0]             sx;
    logic [23:0]            word;
    logic [1:0]             nb;
    logic [COUNT_WIDTH:0]   sum;
    b64d_pkg::status_t      code;
    int                     n;
    int                     k;
    pad = (c == b64d_pkg::PAD_CHAR);
    sx  = pad ? 6'd0 : sextet_value(c);
    n   = 0;
    if (pos == 2'd3) begin
      word = {acc, sx};
      nb   = 2'd3;
      // Padding only shortens the group that closes the string.
      if (fin && pad) nb = nb - 2'd1;
      if (fin && prev_pad) nb = nb - 2'd1;
      for (k = 0; k < nb; k++) begin
        burst[n] = {word[16 - 8*k +: 8], 1'b0, b64d_pkg::ST_OK, 1'b0};
        n++;
      end
      sum        = {1'b0, byte_total} + (COUNT_WIDTH + 1)'(nb);
      byte_total = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      acc        = '0;
      pos        = 2'd0;
    end else if (!fin) begin
      acc = {acc[11:0], sx};
      pos = pos + 2'd1;
    end
    prev_pad = pad;
    if (fin) begin
      if (n == 0) begin
        code = b64d_pkg::ST_BAD_LENGTH;
      end else if (byte_total > want_bytes) begin
        code = b64d_pkg::ST_TOO_LONG;
      end else if (byte_total < want_bytes) begin
        code = b64d_pkg::ST_TOO_SHORT;
      end else begin
        code = b64d_pkg::ST_OK;
      end
      burst[n] = {8'h00, 1'b1, code, 1'b0};
      n++;
      acc        = '0;
      pos        = 2'd0;
      prev_pad   = 1'b0;
      byte_total = '0;
    end
    for (k = 0; k < n; k++) begin
      if (k == n - 1) burst[k].last = 1'b1;
      due_q.push_back(burst[k]);
    end
  endtask

  always @(posedge clk) begin : monitor
    decoded_t got;
    decoded_t want;
    if (rst) begin
      due_q.delete();
      acc        = '0;
      pos        = 2'd0;
      prev_pad   = 1'b0;
      byte_total = '0;
      want_bytes = b64d_pkg::EXP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) want_bytes = cfg_data;
      if (out_valid && !out_stall) begin
        got = {out_byte, is_status, status_code, run_end};
        seen++;
        if (due_q.size() == 0) begin
          report("result with nothing expected", decoded_t'(0), got);
        end else begin
          want = due_q.pop_front();
          if (got.data !== want.data || got.is_stat !== want.is_stat ||
              got.code !== want.code || got.last !== want.last) begin
            report("result mismatch", want, got);
          end
        end
      end
      // A result cannot stem from a character taken at the same edge.
      if (in_valid && !in_stall) decode_char(in_char, final_char);
    end
    outstanding     <= due_q.size();
    fail_count      <= errors;
    results_checked <= seen;
  end

endmodule

// ----- sim/tb_base64_decoder_with_length_check_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_base64_decoder_with_length_check_unit
// Feeds base64 strings to the decoder with random gaps and output stalls,
// sweeps the expected byte count between strings and leaves all checking
// to the stream checker instantiated alongside the block.
// ---------------------------------------------------------------------------
module tb_base64_decoder_with_length_check_unit;

  localparam int COUNT_WIDTH       = 13;
  localparam int RANDOM_CHARS      = 188;
  localparam int SETTLE_CYCLES     = 8;
  localparam int LIMIT_NS          = 5_000_000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_char = 8'h00;
  logic                           final_char = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           is_status;
  logic [1:0]                     status_code;
  logic                           run_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [b64d_pkg::EXP_WIDTH-1:0] cfg_data = b64d_pkg::EXP_RESET;

  int   fail_count;
  int   outstanding;
  int   results_checked;
  int   chars_sent = 0;
  int   strings_sent = 0;
  int   random_chars = 0;
  int   out_wait = 0;
  logic calm = 1'b0;

  logic [7:0] text_q[$];
  string      b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  always #5 clk = ~clk;

  base64_decoder_with_length_check_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char(in_char), .final_char(final_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .is_status(is_status),
    .status_code(status_code), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  b64d_stream_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char(in_char), .final_char(final_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .is_status(is_status),
    .status_code(status_code), .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding),
    .results_checked(results_checked)
  );

  // After each result transaction the sink may raise out_stall, unless calm is set.
  always @(posedge clk) begin : result_backpressure
    int hold;
    if (rst) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      hold = calm ? 0 : $urandom_range(0, 7);
      out_wait  <= hold;
      out_stall <= (hold != 0);
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait  <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic write_expected(input int unsigned value);
    cfg_data  <= value[b64d_pkg::EXP_WIDTH-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Lowers valid in the cycle after the last transaction, then waits for the
  // checker to run dry and lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends the queued text as one string; valid is left high so that the
  // next string may follow without a gap.
  task automatic send_text();
    int gap;
    int k;
    for (k = 0; k < text_q.size(); k++) begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_char    <= text_q[k];
      final_char <= (k == text_q.size() - 1);
      do @(posedge clk); while (in_stall);
    end
    chars_sent   += text_q.size();
    strings_sent += 1;
    text_q.delete();
  endtask

  task automatic load_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
    return b64_alphabet[$urandom_range(0, 63)];
  endfunction

  // Mostly well-formed strings; the rest have a broken length or are noise.
  // The decoded length is returned for well-formed strings, else -1.
  task automatic make_random_string(output int predicted);
    int kind;
    int groups;
    int pads;
    int len;
    int k;
    kind      = $urandom_range(0, 9);
    groups    = $urandom_range(1, 4);
    pads      = $urandom_range(0, 2);
    predicted = -1;
    if (kind == 9) begin
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        text_q.push_back(($urandom_range(0, 3) == 0) ? b64d_pkg::PAD_CHAR
                                                     : 8'($urandom_range(0, 255)));
      end
    end else begin
      for (k = 0; k < 4 * groups - pads; k++) text_q.push_back(pick_char());
      for (k = 0; k < pads; k++) text_q.push_back(b64d_pkg::PAD_CHAR);
      if (kind >= 7) begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) text_q.push_back(pick_char());
      end else begin
        predicted = 3 * groups - pads;
      end
    end
  endtask

  initial begin : stimulus
    int predicted;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short directed strings against the reset count of 32, then 3 and 1.
    load_text("a+9/");
    send_text();
    wait_idle();
    write_expected(3);
    load_text("TWFu");
    send_text();
    load_text("QUI=");
    send_text();
    wait_idle();
    write_expected(1);
    load_text("QQ==");
    send_text();
    load_text("A");
    send_text();
    // Invalid characters and a leading pad, then a stray final character
    // after a group whose bytes have already gone out.
    load_text("=*~ZY");
    send_text();
    wait_idle();

    while (random_chars < RANDOM_CHARS) begin
      make_random_string(predicted);
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       write_expected(1);
          1:       write_expected(4095);
          5:       write_expected($urandom_range(1, 4095));
          default: write_expected(predicted > 0 ? predicted : $urandom_range(1, 40));
        endcase
      end
      random_chars += text_q.size();
      send_text();
    end
    wait_idle();

    $display("Sent %0d strings (%0d characters) with random gaps, stalls and bad lengths;",
             strings_sent, chars_sent);
    $display("checked %0d results with expected counts swept between 1 and 4095.",
             results_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
